@@ rtl/core/ipc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package ipc_pkg;

  // address shape
  localparam int unsigned V4_SEGMENTS   = 4;
  localparam int unsigned V4_MAX_DIGITS = 3;
  localparam int unsigned V4_MAX_VALUE  = 255;
  localparam int unsigned V6_GROUPS     = 8;
  localparam int unsigned V6_MAX_LENGTH = 4;

  localparam logic [7:0] CHAR_DOT   = 8'h2e;
  localparam logic [7:0] CHAR_COLON = 8'h3a;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;

  localparam logic [1:0] VERDICT_IPV4    = 2'd0;
  localparam logic [1:0] VERDICT_IPV6    = 2'd1;
  localparam logic [1:0] VERDICT_NEITHER = 2'd2;

  typedef logic [1:0] verdict_t;

  typedef struct packed {
    logic       seen_dot;
    logic       seen_colon;
    logic       v4_valid;
    logic [2:0] v4_separator_count;
    logic [2:0] v4_digit_count;
    logic [8:0] v4_segment_value;
    logic       v4_first_is_zero;
    logic       v6_valid;
    logic [3:0] v6_separator_count;
    logic [2:0] v6_group_length;
  } ipc_state_t;

  localparam ipc_state_t STATE_RESET = '{
    seen_dot:           1'b0,
    seen_colon:         1'b0,
    v4_valid:           1'b1,
    v4_separator_count: 3'd0,
    v4_digit_count:     3'd0,
    v4_segment_value:   9'd0,
    v4_first_is_zero:   1'b0,
    v6_valid:           1'b1,
    v6_separator_count: 4'd0,
    v6_group_length:    3'd0
  };

endpackage

`default_nettype wire

@@ rtl/core/ipc_step.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ipc_step (
  input  wire ipc_pkg::ipc_state_t state_i,
  input  wire logic [7:0]          char_i,
  output ipc_pkg::ipc_state_t      state_o,
  output ipc_pkg::verdict_t        verdict_o
);

  logic        is_dec;
  logic        is_hex_letter;
  logic [11:0] seg_val;
  logic [3:0]  digit;

  always_comb begin
    is_dec        = char_i inside {[8'h30:8'h39]};
    is_hex_letter = char_i inside {[8'h61:8'h66], [8'h41:8'h46]};
    digit         = 4'(char_i - ipc_pkg::CHAR_ZERO);
    // segment * 10 as two shifts
    seg_val       = {state_i.v4_segment_value, 3'b000} + {2'b00, state_i.v4_segment_value, 1'b0}
                    + {8'd0, digit};
  end

  always_comb begin
    state_o = state_i;
    if (char_i == ipc_pkg::CHAR_DOT) begin
      state_o.seen_dot = 1'b1;
      if (state_i.v4_digit_count == 3'd0) state_o.v4_valid = 1'b0;
      if (state_i.v4_separator_count != 3'd7)
        state_o.v4_separator_count = state_i.v4_separator_count + 3'd1;
      if (state_o.v4_separator_count > 3'(ipc_pkg::V4_SEGMENTS - 1)) state_o.v4_valid = 1'b0;
      state_o.v4_digit_count   = 3'd0;
      state_o.v4_segment_value = 9'd0;
      state_o.v4_first_is_zero = 1'b0;
      state_o.v6_valid         = 1'b0;
    end else if (char_i == ipc_pkg::CHAR_COLON) begin
      state_o.seen_colon = 1'b1;
      state_o.v4_valid   = 1'b0;
      if (state_i.v6_group_length == 3'd0) state_o.v6_valid = 1'b0;
      if (state_i.v6_separator_count != 4'd15)
        state_o.v6_separator_count = state_i.v6_separator_count + 4'd1;
      if (state_o.v6_separator_count > 4'(ipc_pkg::V6_GROUPS - 1)) state_o.v6_valid = 1'b0;
      state_o.v6_group_length = 3'd0;
    end else if (is_dec || is_hex_letter) begin
      if (state_i.v6_group_length != 3'd7)
        state_o.v6_group_length = state_i.v6_group_length + 3'd1;
      if (state_o.v6_group_length > 3'(ipc_pkg::V6_MAX_LENGTH)) state_o.v6_valid = 1'b0;
      if (is_dec) begin
        if (state_i.v4_digit_count == 3'd0) begin
          state_o.v4_first_is_zero = (char_i == ipc_pkg::CHAR_ZERO);
        end else if (state_i.v4_first_is_zero) begin
          state_o.v4_valid = 1'b0;
        end
        if (state_i.v4_digit_count != 3'd7)
          state_o.v4_digit_count = state_i.v4_digit_count + 3'd1;
        if (state_o.v4_digit_count > 3'(ipc_pkg::V4_MAX_DIGITS)) state_o.v4_valid = 1'b0;
        // saturate one above the largest legal value
        if (seg_val > 12'(ipc_pkg::V4_MAX_VALUE)) begin
          state_o.v4_segment_value = 9'(ipc_pkg::V4_MAX_VALUE + 1);
          state_o.v4_valid         = 1'b0;
        end else begin
          state_o.v4_segment_value = seg_val[8:0];
        end
      end else begin
        state_o.v4_valid = 1'b0;
      end
    end else begin
      state_o.v4_valid = 1'b0;
      state_o.v6_valid = 1'b0;
    end
  end

  always_comb begin
    verdict_o = ipc_pkg::VERDICT_NEITHER;
    if (state_o.seen_dot) begin
      if (state_o.v4_valid
          && state_o.v4_separator_count == 3'(ipc_pkg::V4_SEGMENTS - 1)
          && state_o.v4_digit_count != 3'd0
          && state_o.v4_segment_value <= 9'(ipc_pkg::V4_MAX_VALUE))
        verdict_o = ipc_pkg::VERDICT_IPV4;
    end else if (state_o.seen_colon) begin
      if (state_o.v6_valid
          && state_o.v6_separator_count == 4'(ipc_pkg::V6_GROUPS - 1)
          && state_o.v6_group_length != 3'd0)
        verdict_o = ipc_pkg::VERDICT_IPV6;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/ip_address_text_classifier.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Classifies an address string sent one character per request, with in_is_last on the final
// character, as dotted IPv4 (verdict 0), colon-separated IPv6 (verdict 1) or neither (2).
// Exactly one result comes out per string: the last character passes the input register and its
// verdict is then registered in the output register, and the tracking state clears itself for the
// next string. One character is taken every cycle: a character sits in the input register and is
// folded into the state on the next edge, and the only hold-up is a last character whose verdict
// cannot move because the output register still holds an untaken verdict under out_stall.
module ip_address_text_classifier (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_char_code,
  input  wire logic       in_is_last,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [1:0]      out_verdict
);

  logic                s1_vld_r;
  logic [7:0]          s1_char_r;
  logic                s1_last_r;
  ipc_pkg::ipc_state_t state_r;
  ipc_pkg::ipc_state_t state_nxt;
  ipc_pkg::verdict_t   verdict_nxt;
  logic                out_vld_r;
  ipc_pkg::verdict_t   out_verdict_r;
  logic                s1_adv;

  ipc_step u_step (
    .state_i   (state_r),
    .char_i    (s1_char_r),
    .state_o   (state_nxt),
    .verdict_o (verdict_nxt)
  );

  // a last character needs room in the output register
  assign s1_adv   = !(s1_last_r && out_vld_r && out_stall);
  assign in_stall = s1_vld_r && !s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (!in_stall) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_char_r <= in_char_code;
      s1_last_r <= in_is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ipc_pkg::STATE_RESET;
    end else if (s1_vld_r && s1_adv) begin
      state_r <= s1_last_r ? ipc_pkg::STATE_RESET : state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s1_vld_r && s1_adv && s1_last_r) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_vld_r && s1_adv && s1_last_r) begin
      out_verdict_r <= verdict_nxt;
    end
  end

  assign out_valid   = out_vld_r;
  assign out_verdict = out_verdict_r;

endmodule

`default_nettype wire

@@ rtl/core/ipc_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ipc_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic [7:0] in_char_code,
  input wire logic       in_is_last,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [1:0] out_verdict
);

  // the output register comes up empty
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown straight after reset");

  // a held verdict stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_verdict))
    else $error("stalled result dropped or changed");

  // a stalled request keeps its character and flag
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_char_code) && $stable(in_is_last))
    else $error("stalled request dropped or changed");

  // the input only backs up behind a blocked result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output back-pressure");

  a_verdict_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_verdict != 2'd3)
    else $error("verdict code out of range");

endmodule

bind ip_address_text_classifier ipc_checker u_ipc_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .in_char_code (in_char_code),
  .in_is_last   (in_is_last),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_verdict  (out_verdict)
);

`default_nettype wire
